// ===== sv/mvsm_pkg.sv =====
// Shared types and constants for the multi-voice sample mixer.
`timescale 1ns / 1ps

package mvsm_pkg;

    localparam int OP_W      = 2;
    localparam int VOICE_W   = 4;
    localparam int ADDR_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 17;
    localparam int VOL_W     = 7;
    localparam int MASK_W    = 16;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_DESC = 2'd1,
        OP_PLAY = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  position;
        logic [VOL_W-1:0]  gain;
    } voice_entry_t;

    localparam int VE_W = $bits(voice_entry_t);

    localparam int XW = ADDR_W + 2;

    localparam int PROD_W      = SAMPLE_W + VOL_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int QUOT_W      = SAMPLE_W + 1;
    localparam int PCT         = 100;
    localparam int PCT_SHIFT   = MAG_W + 7;
    localparam int PCT_RECIP_W = 23;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
        PCT_RECIP_W'((64'd1 << PCT_SHIFT) / PCT);

    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

endpackage

// ===== sv/mvsm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/multi_voice_sample_mixer_top.sv =====
// Top level of the multi-voice sample mixer: control, voice pipeline and scaling.
`timescale 1ns / 1ps
//
// The input stream carries one command per beat: the operation code on s_tuser and
// its operands on s_tdata. A load writes one word into the sample memory, a
// descriptor sets a voice's start and length, a play restarts a voice with a gain
// and a tick produces one mixed sample on the output stream, together with the
// mask of voices still playing. The master gain is written over the cfg channel,
// which is always ready, and should only be changed while the block is idle.
// After a load beat s_tready stays low until the sample write has left the pipeline,
// and after a descriptor or play beat while the voice entry is rewritten. The output
// beat of a tick appears when s_tready rises again: the voice memory is read once
// per voice, one voice per cycle, and each playing voice then flows through address
// reduction, the sample read and the percentage scaler before the master scaling
// pass.
// Only one command is in progress at a time; s_tready is high while idle, even
// when a finished sample still waits on the output register. If the receiver
// stalls, a second tick holds in its last step until the output beat is taken.
// Reset stops all voices, clears the voice table and sets the master gain to 50;
// the sample memory keeps its contents and must be loaded before it is played.

module multi_voice_sample_mixer_top #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // voice[3:0], address[19:4], sample_value[35:20], length[52:36], volume[59:53]
    input  logic [mvsm_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  logic [mvsm_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_sample[15:0], playing_mask[31:16]
    output logic [mvsm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mvsm_pkg::VOL_W-1:0]       cfg_data
);

    import mvsm_pkg::*;

    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW     = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
    localparam int SHIFT  = XW + AW;
    localparam int RW     = 20;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / SAMPLE_WORDS);
    localparam int MW     = (XW > AW + 1) ? XW : AW + 1;
    localparam logic [MW-1:0] NWORDS = MW'(SAMPLE_WORDS);
    localparam int ACTW   = (VOICES > MASK_W) ? VOICES : MASK_W;
    localparam int SUMW   = SAMPLE_W + VW + 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RMW    = 8'b0000_0010,
        ST_LOAD   = 8'b0000_0100,
        ST_TICK   = 8'b0000_1000,
        ST_DRAIN  = 8'b0001_0000,
        ST_MASTER = 8'b0010_0000,
        ST_MWAIT  = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [VOICE_W-1:0]  in_voice;
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_sample;
    logic [LEN_W-1:0]    in_len;
    logic [VOL_W-1:0]    in_vol;
    op_t                 in_op;
    logic                s_accept;
    logic                voice_ok;

    assign in_voice  = s_tdata[3:0];
    assign in_addr   = s_tdata[19:4];
    assign in_sample = s_tdata[35:20];
    assign in_len    = s_tdata[52:36];
    assign in_vol    = s_tdata[59:53];
    assign in_op     = op_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign voice_ok  = (32'(in_voice) < VOICES);
    assign cfg_ready = 1'b1;

    logic [VOL_W-1:0]  master_reg;
    op_t               op_reg;
    logic [VW-1:0]     vidx_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic [VW-1:0]     idx_reg;
    logic [VOICES-1:0] active_reg;
    logic [VOICES-1:0] vvalid_reg;

    logic signed [SUMW-1:0] sum_reg;
    logic signed [SAMPLE_W-1:0] sum_sat;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Voice memory access
    logic [VW-1:0]   vr_addr;
    logic [VE_W-1:0] vram_rdata;
    logic            vw_en;
    logic [VW-1:0]   vw_addr;
    voice_entry_t    vw_data;
    logic [VW-1:0]   rd_idx;
    voice_entry_t    rd_entry;
    voice_entry_t    merged;
    voice_entry_t    upd;

    // Voice pipeline
    logic              p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [VW-1:0]     p1_idx_reg;
    logic              p1_act_reg;
    logic              hit;
    logic              still;
    logic [LEN_W-1:0]  new_pos;
    logic [XW-1:0]     p1_x;
    logic              p2_load_reg, p3_load_reg;
    logic [XW-1:0]     p2_x_reg, p3_x_reg;
    logic [VOL_W-1:0]  p2_gain_reg, p3_gain_reg, p4_gain_reg;
    logic [SAMPLE_W-1:0] p2_data_reg, p3_data_reg;
    logic [XW+RW-1:0]  xprod;
    logic [XW-1:0]     p3_q_reg;
    logic [MW-1:0]     qn;
    logic [MW-1:0]     r0;
    logic [MW-1:0]     rfix;
    logic [AW-1:0]     saddr;
    logic [SAMPLE_W-1:0] sram_rdata;

    // Percentage scaler
    logic                      sa_valid;
    logic                      sa_master;
    logic signed [SAMPLE_W-1:0] sa_val;
    logic [VOL_W-1:0]          sa_gain;
    logic signed [PROD_W-1:0]  sa_prod;
    logic [MAG_W-1:0]          sa_mag;
    logic                      sc1_v_reg, sc2_v_reg, sc3_v_reg;
    logic                      sc1_m_reg, sc2_m_reg, sc3_m_reg;
    logic                      sc1_neg_reg, sc2_neg_reg;
    logic [MAG_W-1:0]          sc1_mag_reg, sc2_mag_reg;
    logic [MAG_W+PCT_RECIP_W-1:0] sprod;
    logic [QUOT_W-1:0]         sc2_q_reg;
    logic [MAG_W-1:0]          rem;
    logic [QUOT_W-1:0]         qc;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic signed [SAMPLE_W-1:0] sc3_val_reg;

    logic            busy;
    logic [ACTW-1:0] act_ext;

    assign busy = p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg ||
                  sc1_v_reg || sc2_v_reg || sc3_v_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_op) inside
                        OP_LOAD: state_next = ST_LOAD;
                        OP_DESC, OP_PLAY: begin
                            if (voice_ok) begin
                                state_next = ST_RMW;
                            end
                        end
                        OP_TICK: state_next = ST_TICK;
                    endcase
                end
            end
            ST_RMW: state_next = ST_IDLE;
            ST_LOAD: begin
                if (!busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (idx_reg == VW'(VOICES - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    state_next = ST_MASTER;
                end
            end
            ST_MASTER: state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (sc3_v_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Voice table read, merge and write back
    assign vr_addr  = (state_reg == ST_TICK) ? idx_reg : VW'(in_voice);
    assign rd_idx   = (state_reg == ST_RMW) ? vidx_reg : p1_idx_reg;
    assign rd_entry = vvalid_reg[rd_idx] ? voice_entry_t'(vram_rdata) : '0;

    always_comb begin
        merged = rd_entry;
        if (op_reg == OP_DESC) begin
            merged.start  = addr_reg;
            merged.length = len_reg;
        end else begin
            merged.gain     = vol_reg;
            merged.position = '0;
        end
    end

    assign hit     = p1_act_reg && (rd_entry.position < rd_entry.length);
    assign new_pos = rd_entry.position + 1'b1;
    assign still   = hit && (new_pos < rd_entry.length);
    assign p1_x    = XW'(rd_entry.start) + XW'(rd_entry.position);

    always_comb begin
        upd          = rd_entry;
        upd.position = new_pos;
    end

    always_comb begin
        vw_en   = 1'b0;
        vw_addr = p1_idx_reg;
        vw_data = upd;
        if (state_reg == ST_RMW) begin
            vw_en   = 1'b1;
            vw_addr = vidx_reg;
            vw_data = merged;
        end else if (p1_v_reg && hit) begin
            vw_en = 1'b1;
        end
    end

    mvsm_ram #(
        .WIDTH (VE_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .aclk  (aclk),
        .we    (vw_en),
        .waddr (vw_addr),
        .wdata (vw_data),
        .re    (1'b1),
        .raddr (vr_addr),
        .rdata (vram_rdata)
    );

    // Sample address reduction modulo the memory size
    assign xprod = (XW+RW)'(p2_x_reg) * (XW+RW)'(RECIP);
    assign qn    = MW'(p3_q_reg) * NWORDS;
    assign r0    = MW'(p3_x_reg) - qn;
    assign rfix  = (r0 >= NWORDS) ? (r0 - NWORDS) : r0;
    assign saddr = AW'(rfix);

    mvsm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (p3_v_reg && p3_load_reg),
        .waddr (saddr),
        .wdata (p3_data_reg),
        .re    (p3_v_reg && !p3_load_reg),
        .raddr (saddr),
        .rdata (sram_rdata)
    );

    // Sum saturation and scaler input selection
    always_comb begin
        if (sum_reg > SUMW'(S16_MAX)) begin
            sum_sat = S16_MAX;
        end else if (sum_reg < SUMW'(S16_MIN)) begin
            sum_sat = S16_MIN;
        end else begin
            sum_sat = SAMPLE_W'(sum_reg);
        end
    end

    assign sa_master = (state_reg == ST_MASTER);
    assign sa_valid  = p4_v_reg || sa_master;
    assign sa_val    = p4_v_reg ? $signed(sram_rdata) : sum_sat;
    assign sa_gain   = p4_v_reg ? p4_gain_reg : master_reg;
    assign sa_prod   = PROD_W'(sa_val) * $signed(PROD_W'(sa_gain));
    assign sa_mag    = sa_prod[PROD_W-1] ? MAG_W'(-sa_prod) : MAG_W'(sa_prod);

    assign sprod = (MAG_W+PCT_RECIP_W)'(sc1_mag_reg) * (MAG_W+PCT_RECIP_W)'(PCT_RECIP);
    assign rem   = sc2_mag_reg - MAG_W'(MAG_W'(sc2_q_reg) * MAG_W'(PCT));
    assign qc    = (rem >= MAG_W'(PCT)) ? (sc2_q_reg + 1'b1) : sc2_q_reg;

    always_comb begin
        if (!sc2_neg_reg) begin
            sat_val = (qc > QUOT_W'(32767)) ? S16_MAX : $signed(SAMPLE_W'(qc));
        end else begin
            sat_val = (qc > QUOT_W'(32768)) ? S16_MIN : -$signed(SAMPLE_W'(qc));
        end
    end

    assign act_ext = ACTW'(active_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            master_reg   <= VOL_W'(50);
            active_reg   <= '0;
            vvalid_reg   <= '0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            p4_v_reg     <= 1'b0;
            sc1_v_reg    <= 1'b0;
            sc2_v_reg    <= 1'b0;
            sc3_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                master_reg <= cfg_data;
            end
            if (vw_en) begin
                vvalid_reg[vw_addr] <= 1'b1;
            end
            if (state_reg == ST_RMW && op_reg == OP_PLAY) begin
                active_reg[vidx_reg] <= 1'b1;
            end
            if (p1_v_reg) begin
                active_reg[p1_idx_reg] <= still;
            end
            p1_v_reg  <= (state_reg == ST_TICK);
            p2_v_reg  <= (s_accept && in_op == OP_LOAD) || (p1_v_reg && hit);
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg && !p3_load_reg;
            sc1_v_reg <= sa_valid;
            sc2_v_reg <= sc1_v_reg;
            sc3_v_reg <= sc2_v_reg;
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= in_op;
            vidx_reg <= VW'(in_voice);
            addr_reg <= in_addr;
            len_reg  <= in_len;
            vol_reg  <= in_vol;
        end
        if (s_accept && in_op == OP_TICK) begin
            idx_reg <= '0;
        end else if (state_reg == ST_TICK) begin
            idx_reg <= VW'(idx_reg + 1'b1);
        end
        if (s_accept && in_op == OP_TICK) begin
            sum_reg <= '0;
        end else if (sc3_v_reg && !sc3_m_reg) begin
            sum_reg <= sum_reg + SUMW'(sc3_val_reg);
        end

        p1_idx_reg <= idx_reg;
        p1_act_reg <= active_reg[idx_reg];

        if (s_accept) begin
            p2_load_reg <= 1'b1;
            p2_x_reg    <= XW'(in_addr);
            p2_data_reg <= in_sample;
        end else begin
            p2_load_reg <= 1'b0;
            p2_x_reg    <= p1_x;
        end
        p2_gain_reg <= rd_entry.gain;

        p3_q_reg    <= XW'(xprod >> SHIFT);
        p3_x_reg    <= p2_x_reg;
        p3_load_reg <= p2_load_reg;
        p3_gain_reg <= p2_gain_reg;
        p3_data_reg <= p2_data_reg;

        p4_gain_reg <= p3_gain_reg;

        sc1_m_reg   <= sa_master;
        sc1_neg_reg <= sa_prod[PROD_W-1];
        sc1_mag_reg <= sa_mag;

        sc2_m_reg   <= sc1_m_reg;
        sc2_neg_reg <= sc1_neg_reg;
        sc2_mag_reg <= sc1_mag_reg;
        sc2_q_reg   <= QUOT_W'(sprod >> PCT_SHIFT);

        sc3_m_reg   <= sc2_m_reg;
        sc3_val_reg <= sat_val;

        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {act_ext[MASK_W-1:0], sc3_val_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
